@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SMX_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define SMX_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/smx_pkg.sv @@
package smx_pkg;

  localparam logic [2:0] REQ_LIT  = 3'd0;
  localparam logic [2:0] REQ_CALL = 3'd1;
  localparam logic [2:0] REQ_JMP  = 3'd2;
  localparam logic [2:0] REQ_JZ   = 3'd3;
  localparam logic [2:0] REQ_STR  = 3'd4;
  localparam logic [2:0] REQ_HALT = 3'd5;

  localparam logic [3:0] BI_ADD   = 4'd0;
  localparam logic [3:0] BI_SUB   = 4'd1;
  localparam logic [3:0] BI_MUL   = 4'd2;
  localparam logic [3:0] BI_DIV   = 4'd3;
  localparam logic [3:0] BI_PNUM  = 4'd4;
  localparam logic [3:0] BI_PSTR  = 4'd5;
  localparam logic [3:0] BI_STORE = 4'd6;
  localparam logic [3:0] BI_FETCH = 4'd7;
  localparam logic [3:0] BI_DUP   = 4'd8;
  localparam logic [3:0] BI_DROP  = 4'd9;
  localparam logic [3:0] BI_SWAP  = 4'd10;
  localparam logic [3:0] BI_EQ    = 4'd11;
  localparam logic [3:0] BI_LT    = 4'd12;
  localparam logic [3:0] BI_GT    = 4'd13;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_CALL,
    OP_JMP,
    OP_JZ,
    OP_HALT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_DIVZERO = 3'd1,
    ERR_SLOT    = 3'd2,
    ERR_UNDER   = 3'd3,
    ERR_OVER    = 3'd4,
    ERR_BUILTIN = 3'd5
  } err_t;

  typedef struct packed {
    op_t         op;
    logic        bad_bi;
    logic [3:0]  bi;
    logic [1:0]  pops;
    logic        grow;
    logic [31:0] operand;
  } req_t;

  typedef struct packed {
    logic        jump_taken;
    logic [15:0] jump_target;
    logic        print_valid;
    logic        print_kind;
    logic [31:0] print_value;
    err_t        error_code;
    logic        halt;
    logic [6:0]  depth_after;
  } res_t;

endpackage

@@ src/stack_machine_execute_core.sv @@
// Flow: a request passes the queue, then back-end states S_IDLE, S_EXEC and S_OUT, with
//   S_SWAP for swap, S_FETCH for fetch and S_DIV for divide (32 bit-serial quotient steps).
// The sequencer in the back end handles one request at a time over a single stack write
//   port, and takes no new request from the queue until the last result is handed out.
// Reset: synchronous, active low; clears stack depth and queue, then sweeps the variable
//   store to zero slot by slot with in_tready held low.
`include "assert_macros.svh"

module stack_machine_execute_core #(
  parameter int STACK_DEPTH    = 64,
  parameter int VAR_SLOTS      = 64,
  parameter int PROG_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // operand
  input  logic [2:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  // jump_taken, jump_target[15:0], print_valid, print_value[31:0], error_code[2:0],
  // halt, depth_after[6:0], zero pad
  output logic [63:0] out_tdata,
  output logic        out_tuser   // print_kind
);
  import smx_pkg::*;

  logic clearing;
  logic q_wr_valid;
  logic q_wr_ready;
  req_t q_wr_data;
  logic q_rd_valid;
  logic q_rd_ready;
  req_t q_rd_data;

  smx_front u_front (
    .enable     (~clearing),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  smx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  smx_back #(
    .STACK_DEPTH    (STACK_DEPTH),
    .VAR_SLOTS      (VAR_SLOTS),
    .PROG_ADDR_BITS (PROG_ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (clearing),
    .q_rd_valid (q_rd_valid),
    .q_rd_ready (q_rd_ready),
    .q_rd_data  (q_rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `SMX_AST_IMP(a_jump_clean, out_tvalid && !out_tdata[0], out_tdata[16:1] == 16'd0)
  `SMX_AST_IMP(a_print_clean, out_tvalid && !out_tdata[17], out_tdata[49:18] == 32'd0 && !out_tuser)
  `SMX_AST_IMP(a_err_quiet, out_tvalid && out_tdata[52:50] != ERR_NONE, !out_tdata[0] && !out_tdata[17])
  `SMX_AST_NXT(a_queue_fill, in_tvalid && in_tready, q_rd_valid)

endmodule

@@ src/smx_front.sv @@
module smx_front (
  input  logic               enable,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic [2:0]         in_tuser,
  output logic               q_wr_valid,
  input  logic               q_wr_ready,
  output smx_pkg::req_t      q_wr_data
);
  import smx_pkg::*;

  logic [3:0] bi;

  assign in_tready  = enable & q_wr_ready;
  assign q_wr_valid = enable & in_tvalid;
  assign bi         = in_tdata[3:0];

  always_comb begin
    q_wr_data         = '0;
    q_wr_data.op      = OP_NOP;
    q_wr_data.operand = in_tdata;
    unique case (in_tuser) inside
      REQ_LIT, REQ_STR: begin
        q_wr_data.op   = OP_PUSH;
        q_wr_data.grow = 1'b1;
      end
      REQ_CALL: begin
        q_wr_data.op     = OP_CALL;
        q_wr_data.bad_bi = (in_tdata > 32'd13);
        q_wr_data.bi     = bi;
        q_wr_data.pops   = (bi inside {BI_PNUM, BI_PSTR, BI_FETCH, BI_DUP, BI_DROP}) ?
                           2'd1 : 2'd2;
        q_wr_data.grow   = (bi == BI_DUP);
      end
      REQ_JMP: q_wr_data.op = OP_JMP;
      REQ_JZ: begin
        q_wr_data.op   = OP_JZ;
        q_wr_data.pops = 2'd1;
      end
      REQ_HALT: q_wr_data.op = OP_HALT;
      default:  q_wr_data.op = OP_NOP;
    endcase
  end

endmodule

@@ src/smx_queue.sv @@
module smx_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  smx_pkg::req_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output smx_pkg::req_t rd_data
);
  import smx_pkg::*;

  req_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid & wr_ready;
  assign rd_en    = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (rd_en) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

@@ src/smx_div.sv @@
module smx_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;
  logic [4:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign done    = done_r;
  assign quot    = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 5'd0;
        rem_r  <= 32'd0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        // one quotient bit per cycle, restoring
        rem_r  <= diff[32] ? shifted[31:0] : diff[31:0];
        quo_r  <= {quo_r[30:0], ~diff[32]};
        step_r <= step_r + 5'd1;
        if (step_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/smx_back.sv @@
module smx_back #(
  parameter int STACK_DEPTH    = 64,
  parameter int VAR_SLOTS      = 64,
  parameter int PROG_ADDR_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          clearing,
  input  logic          q_rd_valid,
  output logic          q_rd_ready,
  input  smx_pkg::req_t q_rd_data,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,
  output logic          out_tuser
);
  import smx_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
  localparam logic [31:0] AMASK = 32'((64'd1 << PROG_ADDR_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_FETCH,
    S_DIV,
    S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  req_t          req_r, req_nxt;
  res_t          res_r, res_nxt;
  res_t          out_res_r;
  logic          out_valid_r;
  logic [VW-1:0] clr_r;
  logic [31:0]   a_r, a_nxt;
  logic          neg_r, neg_nxt;

  logic [31:0]   stack_mem [STACK_DEPTH];
  logic [31:0]   var_mem [VAR_SLOTS];
  logic [31:0]   rd0_r;
  logic [31:0]   rd1_r;
  logic [31:0]   var_rd_r;

  logic          st_we;
  logic [AW-1:0] st_wa;
  logic [31:0]   st_wd;
  logic          var_we;
  logic [VW-1:0] var_wa;
  logic [31:0]   var_wd;
  logic          div_start;
  logic          div_done;
  logic [31:0]   div_q;
  logic [31:0]   ma;
  logic [31:0]   mb;

  logic [31:0]   a;
  logic [31:0]   b;
  logic [AW-1:0] top_a;
  logic [AW-1:0] sec_a;
  logic [AW-1:0] new_a;
  logic          out_free;
  logic          slot_ok;

  assign a        = rd1_r;
  assign b        = rd0_r;
  assign top_a    = AW'(cnt_r - CW'(1));
  assign sec_a    = AW'(cnt_r - CW'(2));
  assign new_a    = AW'(cnt_r);
  assign out_free = ~out_valid_r | out_tready;
  assign slot_ok  = (b < 32'(VAR_SLOTS));
  assign ma       = a[31] ? (32'd0 - a) : a;
  assign mb       = b[31] ? (32'd0 - b) : b;

  assign clearing   = (state_r == S_CLEAR);
  assign q_rd_ready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.print_kind;
  assign out_tdata  = {3'd0, out_res_r.depth_after, out_res_r.halt, out_res_r.error_code,
                       out_res_r.print_value, out_res_r.print_valid,
                       out_res_r.jump_target, out_res_r.jump_taken};

  smx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ma),
    .divisor  (mb),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    a_nxt     = a_r;
    neg_nxt   = neg_r;
    st_we     = 1'b0;
    st_wa     = sec_a;
    st_wd     = 32'd0;
    var_we    = 1'b0;
    var_wa    = b[VW-1:0];
    var_wd    = a;
    div_start = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        var_we = 1'b1;
        var_wa = clr_r;
        var_wd = 32'd0;
        if (clr_r == VW'(VAR_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_rd_valid) begin
          req_nxt   = q_rd_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt            = '0;
        res_nxt.error_code = ERR_NONE;
        state_nxt          = S_OUT;
        unique case (req_r.op)
          OP_PUSH: begin
            if (cnt_r >= CW'(STACK_DEPTH)) begin
              res_nxt.error_code = ERR_OVER;
            end else begin
              st_we   = 1'b1;
              st_wa   = new_a;
              st_wd   = req_r.operand;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          OP_JMP: begin
            res_nxt.jump_taken  = 1'b1;
            res_nxt.jump_target = 16'(req_r.operand & AMASK);
          end
          OP_JZ: begin
            if (cnt_r == CW'(0)) begin
              res_nxt.error_code = ERR_UNDER;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
              if (b == 32'd0) begin
                res_nxt.jump_taken  = 1'b1;
                res_nxt.jump_target = 16'(req_r.operand & AMASK);
              end
            end
          end
          OP_HALT: res_nxt.halt = 1'b1;
          OP_CALL: begin
            if (req_r.bad_bi) begin
              res_nxt.error_code = ERR_BUILTIN;
            end else if (cnt_r < CW'(req_r.pops)) begin
              res_nxt.error_code = ERR_UNDER;
            end else if (req_r.grow && cnt_r >= CW'(STACK_DEPTH)) begin
              res_nxt.error_code = ERR_OVER;
            end else begin
              case (req_r.bi) inside
                BI_PNUM, BI_PSTR: begin
                  res_nxt.print_valid = 1'b1;
                  res_nxt.print_kind  = (req_r.bi == BI_PSTR);
                  res_nxt.print_value = b;
                  cnt_nxt             = cnt_r - CW'(1);
                end
                BI_FETCH: begin
                  if (slot_ok) begin
                    state_nxt = S_FETCH;
                  end else begin
                    res_nxt.error_code = ERR_SLOT;
                    cnt_nxt            = cnt_r - CW'(1);
                  end
                end
                BI_DUP: begin
                  st_we   = 1'b1;
                  st_wa   = new_a;
                  st_wd   = b;
                  cnt_nxt = cnt_r + CW'(1);
                end
                BI_DROP: cnt_nxt = cnt_r - CW'(1);
                BI_STORE: begin
                  if (slot_ok) begin
                    var_we = 1'b1;
                  end else begin
                    res_nxt.error_code = ERR_SLOT;
                  end
                  cnt_nxt = cnt_r - CW'(2);
                end
                BI_SWAP: begin
                  st_we     = 1'b1;
                  st_wd     = b;
                  a_nxt     = a;
                  state_nxt = S_SWAP;
                end
                BI_DIV: begin
                  if (b == 32'd0) begin
                    res_nxt.error_code = ERR_DIVZERO;
                    cnt_nxt            = cnt_r - CW'(2);
                  end else begin
                    div_start = 1'b1;
                    neg_nxt   = a[31] ^ b[31];
                    state_nxt = S_DIV;
                  end
                end
                BI_ADD: begin
                  st_we   = 1'b1;
                  st_wd   = a + b;
                  cnt_nxt = cnt_r - CW'(1);
                end
                BI_SUB: begin
                  st_we   = 1'b1;
                  st_wd   = a - b;
                  cnt_nxt = cnt_r - CW'(1);
                end
                BI_MUL: begin
                  st_we   = 1'b1;
                  st_wd   = a * b;
                  cnt_nxt = cnt_r - CW'(1);
                end
                BI_EQ: begin
                  st_we   = 1'b1;
                  st_wd   = {31'd0, a == b};
                  cnt_nxt = cnt_r - CW'(1);
                end
                BI_LT: begin
                  st_we   = 1'b1;
                  st_wd   = {31'd0, $signed(a) < $signed(b)};
                  cnt_nxt = cnt_r - CW'(1);
                end
                default: begin
                  st_we   = 1'b1;
                  st_wd   = {31'd0, $signed(b) < $signed(a)};
                  cnt_nxt = cnt_r - CW'(1);
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      S_SWAP: begin
        st_we     = 1'b1;
        st_wa     = top_a;
        st_wd     = a_r;
        state_nxt = S_OUT;
      end
      S_FETCH: begin
        st_we     = 1'b1;
        st_wa     = top_a;
        st_wd     = var_rd_r;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          st_we     = 1'b1;
          st_wd     = neg_r ? (32'd0 - div_q) : div_q;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (state_nxt == S_OUT && state_r != S_OUT) begin
      res_nxt.depth_after = 7'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_wa] <= st_wd;
    end
    rd0_r <= stack_mem[top_a];
    rd1_r <= stack_mem[sec_a];
  end

  always_ff @(posedge clk) begin
    if (var_we) begin
      var_mem[var_wa] <= var_wd;
    end
    var_rd_r <= var_mem[b[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    a_r   <= a_nxt;
    neg_r <= neg_nxt;
    if (state_r == S_OUT && out_free) begin
      out_res_r <= res_r;
    end
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + VW'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ tb/stack_machine_execute_core_test.sv @@
module stack_machine_execute_core_test;
  import smx_pkg::*;

  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam int DEPTH = 64;
  localparam int SLOTS = 64;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] opnd;
    bit          drain;
  } instr_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  stack_machine_execute_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  instr_t      pending_q[$];
  res_t        expected_q[$];
  instr_t      cur;
  logic [31:0] stk[DEPTH];
  int          depth;
  logic [31:0] vars[SLOTS];
  int          errors = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          long_hold_done = 0;

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // advance the machine state by one instruction and return its result
  function automatic res_t execute(instr_t ins);
    res_t        r;
    int          need;
    logic [31:0] a, b;
    r = '0;
    r.error_code = ERR_NONE;
    case (ins.kind)
      REQ_LIT, REQ_STR: begin
        if (depth >= DEPTH) r.error_code = ERR_OVER;
        else begin stk[depth] = ins.opnd; depth++; end
      end
      REQ_CALL: begin
        if (ins.opnd > 32'(BI_GT)) r.error_code = ERR_BUILTIN;
        else begin
          need = (ins.opnd[3:0] inside {BI_PNUM, BI_PSTR, BI_FETCH, BI_DUP, BI_DROP}) ? 1 : 2;
          if (depth < need) r.error_code = ERR_UNDER;
          else if (ins.opnd[3:0] == BI_DUP && depth >= DEPTH) r.error_code = ERR_OVER;
          else if (need == 1) begin
            depth--; a = stk[depth];
            case (ins.opnd[3:0])
              BI_PNUM: begin r.print_valid = 1; r.print_value = a; end
              BI_PSTR: begin r.print_valid = 1; r.print_kind = 1; r.print_value = a; end
              BI_FETCH: begin
                if (a < SLOTS) begin stk[depth] = vars[a]; depth++; end
                else r.error_code = ERR_SLOT;
              end
              BI_DUP: begin stk[depth] = a; stk[depth+1] = a; depth += 2; end
              default: ;
            endcase
          end else begin
            depth--; b = stk[depth];
            depth--; a = stk[depth];
            case (ins.opnd[3:0])
              BI_ADD: begin stk[depth] = a + b; depth++; end
              BI_SUB: begin stk[depth] = a - b; depth++; end
              BI_MUL: begin stk[depth] = a * b; depth++; end
              BI_DIV: begin
                if (b == 0) r.error_code = ERR_DIVZERO;
                else begin stk[depth] = div_trunc(a, b); depth++; end
              end
              BI_STORE: begin
                if (b < SLOTS) vars[b] = a;
                else r.error_code = ERR_SLOT;
              end
              BI_SWAP: begin stk[depth] = b; stk[depth+1] = a; depth += 2; end
              BI_EQ: begin stk[depth] = (a == b); depth++; end
              BI_LT: begin stk[depth] = ($signed(a) < $signed(b)); depth++; end
              default: begin stk[depth] = ($signed(b) < $signed(a)); depth++; end
            endcase
          end
        end
      end
      REQ_JMP: begin r.jump_taken = 1; r.jump_target = ins.opnd[15:0]; end
      REQ_JZ: begin
        if (depth < 1) r.error_code = ERR_UNDER;
        else begin
          depth--;
          if (stk[depth] == 0) begin r.jump_taken = 1; r.jump_target = ins.opnd[15:0]; end
        end
      end
      REQ_HALT: r.halt = 1;
      default: ;
    endcase
    r.depth_after = 7'(depth);
    return r;
  endfunction

  // sender: bursts with gaps; hold a valid request until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(execute(cur));
      if (in_tvalid && !in_tready) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain && expected_q.size() > 0)) begin
        cur = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= cur.opnd;
        in_tuser <= cur.kind;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall pattern, one long hold-off midway
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        res_t got, want;
        got = res_t'({out_tdata[0], out_tdata[16:1], out_tdata[17], out_tuser,
                      out_tdata[49:18], out_tdata[52:50], out_tdata[53], out_tdata[60:54]});
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.jump_taken !== want.jump_taken) begin
            $error("jump_taken exp %0d got %0d", want.jump_taken, got.jump_taken); errors++;
          end
          if (got.jump_target !== want.jump_target) begin
            $error("jump_target exp %h got %h", want.jump_target, got.jump_target); errors++;
          end
          if (got.print_valid !== want.print_valid) begin
            $error("print_valid exp %0d got %0d", want.print_valid, got.print_valid); errors++;
          end
          if (got.print_kind !== want.print_kind) begin
            $error("print_kind exp %0d got %0d", want.print_kind, got.print_kind); errors++;
          end
          if (got.print_value !== want.print_value) begin
            $error("print_value exp %h got %h", want.print_value, got.print_value); errors++;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code exp %0d got %0d", want.error_code, got.error_code); errors++;
          end
          if (got.halt !== want.halt) begin
            $error("halt exp %0d got %0d", want.halt, got.halt); errors++;
          end
          if (got.depth_after !== want.depth_after) begin
            $error("depth_after exp %0d got %0d", want.depth_after, got.depth_after); errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1;
        hold_left = 400;
        out_tready <= 1'b0;
      end else if (results_seen % 100 < 40) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic add(logic [2:0] k, logic [31:0] v, bit drain = 0);
    instr_t i;
    i.kind = k; i.opnd = v; i.drain = drain;
    pending_q.push_back(i);
  endtask

  task automatic add_call(logic [3:0] bi);
    add(REQ_CALL, 32'(bi));
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] slot_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return SLOTS;
      default: return $urandom_range(0, SLOTS - 1);
    endcase
  endfunction

  initial begin
    int n;
    for (int i = 0; i < SLOTS; i++) vars[i] = '0;
    depth = 0;

    // directed: underflow on empty, unused types, bad builtins, extremes, div, store, fetch, pstr
    add(REQ_JZ, 32'h0000_0010);
    add_call(BI_ADD);
    add(REQ_SPARE6, 32'hFFFF_FFFF);
    add(REQ_SPARE7, 32'h0);
    add(REQ_CALL, 32'd14);
    add(REQ_CALL, 32'hFFFF_FFFF);
    add(REQ_JMP, 32'hFFFF_FFFF);
    add(REQ_HALT, 32'h0);
    add(REQ_LIT, 32'h8000_0000);
    add(REQ_LIT, 32'hFFFF_FFFF);
    add_call(BI_DIV);
    add(REQ_LIT, 32'd7);
    add(REQ_LIT, 32'd0);
    add_call(BI_DIV);
    add(REQ_LIT, 32'd63);
    add_call(BI_STORE);
    add(REQ_LIT, 32'd63);
    add_call(BI_FETCH);
    add(REQ_LIT, 32'hFFFF_FFFF);
    add_call(BI_FETCH);
    add(REQ_STR, 32'h7FFF_FFFF);
    add_call(BI_PSTR);
    add(REQ_JZ, 32'h0001_2345, 1);

    // random well-formed sequences with some noise
    n = 0;
    while (n < 550) begin
      case ($urandom_range(0, 13))
        0: begin add(REQ_LIT, any_value()); add(REQ_LIT, any_value());
                 add_call(4'($urandom_range(0, 13))); n += 3; end
        1: begin add(REQ_LIT, any_value()); add(REQ_LIT, $urandom_range(0, 2) ? any_value() : 0);
                 add_call(BI_DIV); n += 3; end
        2: begin add(REQ_LIT, any_value()); add(REQ_LIT, slot_value());
                 add_call(BI_STORE); n += 3; end
        3: begin add(REQ_LIT, slot_value()); add_call(BI_FETCH); add_call(BI_PNUM); n += 3; end
        4: begin add(REQ_LIT, any_value()); add_call(BI_DUP); add_call(BI_SWAP);
                 add_call(BI_DROP); n += 4; end
        5: begin add(REQ_STR, $urandom); add_call(BI_PSTR); n += 2; end
        6: begin add(REQ_LIT, $urandom_range(0, 1)); add(REQ_JZ, $urandom); n += 2; end
        7: begin add(REQ_JMP, $urandom); add(REQ_HALT, $urandom); n += 2; end
        8: begin add(3'($urandom_range(0, 7)), $urandom); n += 1; end
        9: begin add(REQ_CALL, $urandom_range(0, 2) ? $urandom_range(0, 15) : $urandom);
                 n += 1; end
        10: begin add_call(BI_DROP); add_call(BI_DROP); add_call(BI_DROP); n += 3; end
        11: begin add(REQ_LIT, any_value()); add(REQ_LIT, any_value());
                  add_call(4'($urandom_range(11, 13))); add_call(BI_PNUM); n += 4; end
        12: begin add(REQ_LIT, any_value()); add_call(BI_PNUM); n += 2; end
        default: begin
          // fill to overflow then unwind
          if (n > 150 && $urandom_range(0, 3) == 0) begin
            for (int i = 0; i < DEPTH + 2; i++) add($urandom_range(0, 1) ? REQ_LIT : REQ_STR, $urandom);
            add_call(BI_DUP);
            for (int i = 0; i < DEPTH + 2; i++) add_call(BI_DROP);
            n += 2 * DEPTH + 5;
          end
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
